[src/tamr_pkg.sv]
`default_nettype none

package tamr_pkg;

    // Default mask geometry
    localparam int MASK_COLS_DEF = 512;
    localparam int MASK_ROWS_DEF = 512;

    // Configuration port
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] AREA_RESET = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS_IN_USE = 1'b0,
        REG_ROWS_IN_USE = 1'b1
    } cfg_reg_t;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_GLYPH     = 2'd0,
        REQ_UNDERLINE = 2'd1,
        REQ_STRIKE    = 2'd2,
        REQ_READ      = 2'd3
    } req_type_t;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 12;
    localparam int BEAR_W  = 9;
    localparam int GPOS_W  = 8;
    localparam int PIX_W   = 8;
    localparam int SPAN_W  = 11;
    localparam int FONT_W  = 8;

    // Input tdata layout, lowest bit first
    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + POS_W;
    localparam int LEFT_LSB   = POS_Y_LSB + POS_W;
    localparam int TOP_LSB    = LEFT_LSB + BEAR_W;
    localparam int GROW_LSB   = TOP_LSB + BEAR_W;
    localparam int GCOL_LSB   = GROW_LSB + GPOS_W;
    localparam int PIX_LSB    = GCOL_LSB + GPOS_W;
    localparam int SPAN_LSB   = PIX_LSB + PIX_W;
    localparam int FONT_LSB   = SPAN_LSB + SPAN_W;
    localparam int S_FIELDS_W = FONT_LSB + FONT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Signed width of all intermediate pixel coordinates
    localparam int CW = 14;

    localparam logic [PIX_W-1:0] ALPHA_FULL = 8'hFF;

    // Reciprocals for exact division by constants on narrow values
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam logic [11:0] DIV18_RECIP = 12'd3641;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div;
        logic coord;
        logic clip;
        logic base;
        logic rd;
        logic merge;
        logic fill_step;
        logic out_load;
    } tamr_cmd_t;

    typedef struct packed {
        logic      clr_last;
        logic      go;
        req_type_t kind;
        logic      col_end;
        logic      row_end;
    } tamr_sts_t;

    // floor(n/10) for n below 2048
    function automatic logic [7:0] div10(input logic [10:0] n);
        logic [26:0] p;
        p = 27'(n) * 27'(DIV10_RECIP);
        return p[26:19];
    endfunction

    // floor(n/18) for n below 256
    function automatic logic [3:0] div18(input logic [7:0] n);
        logic [19:0] p;
        p = 20'(n) * 20'(DIV18_RECIP);
        return p[19:16];
    endfunction

endpackage

`default_nettype wire

[src/text_alpha_mask_raster_unit.sv]
`default_nettype none

// Alpha mask rasterizer for text: an 8-bit mask of MASK_ROWS x MASK_COLS pixels.
// Input stream (s_): one request per transfer; s_tuser holds the request kind
// (glyph pixel, underline, strikethrough, read). Result stream (m_): one result
// per request; m_tdata is the read pixel (zero unless a read), m_tuser is set
// when any pixel was written or the read hit the area in use.
// Configuration: cfg_we with cfg_index 0 sets cols_in_use, 1 sets rows_in_use;
// write only while no request is in flight.
// Timing: a glyph pixel or read passes the divide, coordinate, clip, address
// and read-modify-write steps on the one memory port before m_tvalid rises.
// A fill passes the divide, coordinate, clip and address steps and then writes
// one pixel per cycle; an empty or clipped request skips the pixel steps. One
// request is in work at a time; the next one is accepted only once the result
// has been loaded into the output register.
// Reset: aresetn low clears the area registers to 512 and starts a clearing pass
// that writes zero to all MASK_ROWS*MASK_COLS pixels, one per cycle (262144
// pixels at the default size); s_tready stays low until it ends.
// Stall: while m_tready is low the result holds and the block stops before
// loading the next result.
module text_alpha_mask_raster_unit import tamr_pkg::*; #(
    parameter int MASK_COLS = MASK_COLS_DEF,
    parameter int MASK_ROWS = MASK_ROWS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pos_x, pos_y, glyph_left, glyph_top, glyph_row, glyph_col, pixel_value,
    // span_width, font_size, zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_value
    output logic [M_TDATA_W-1:0]      m_tdata,
    // landed
    output logic                      m_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    tamr_cmd_t cmd;
    tamr_sts_t sts;

    tamr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tamr_dp #(
        .MASK_COLS (MASK_COLS),
        .MASK_ROWS (MASK_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[src/tamr_ram.sv]
`default_nettype none

module tamr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/tamr_dp.sv]
`default_nettype none

module tamr_dp import tamr_pkg::*; #(
    parameter int MASK_COLS = MASK_COLS_DEF,
    parameter int MASK_ROWS = MASK_ROWS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [REQ_W-1:0]     s_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire tamr_cmd_t            cmd,
    output tamr_sts_t                 sts,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    localparam int DEPTH = MASK_COLS * MASK_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // Configuration
    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [CFG_W-1:0] area_cols, area_rows;

    // Captured request
    req_type_t                kind_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [BEAR_W-1:0] left_reg, top_reg;
    logic [GPOS_W-1:0]        grow_reg, gcol_reg;
    logic [PIX_W-1:0]         pv_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [FONT_W-1:0]        fs_reg;

    // Divide stage
    logic signed [8:0] shift_reg, shift_next;
    logic [4:0]        off_reg, off_next;
    logic [3:0]        thick_reg, thick_next;

    // Coordinate stage
    logic signed [CW-1:0] row_lo_reg, row_hi_reg, col_lo_reg, col_hi_reg;
    logic signed [CW-1:0] row_lo_next, row_hi_next, col_lo_next, col_hi_next;

    // Clip stage and pixel walk
    logic [CFG_W-1:0] row_reg, row_last_reg, col_reg, col_first_reg, col_last_reg;
    logic             ok_reg, ok_next;
    logic [AW-1:0]    row_base_reg;

    logic [PIX_W-1:0]     value_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Memory port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_addr, pix_addr;
    logic [PIX_W-1:0] ram_wdata, ram_rdata;

    // Area in use never exceeds the mask
    assign area_cols = (int'(cols_reg) < MASK_COLS) ? cols_reg : CFG_W'(MASK_COLS);
    assign area_rows = (int'(rows_reg) < MASK_ROWS) ? rows_reg : CFG_W'(MASK_ROWS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= AREA_RESET;
            rows_reg <= AREA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLS_IN_USE: cols_reg <= cfg_wdata;
                REG_ROWS_IN_USE: rows_reg <= cfg_wdata;
            endcase
        end
    end

    // Shear shift and line metrics
    always_comb begin
        logic signed [9:0] v;
        logic [9:0]        a;
        logic [10:0]       n;
        logic [7:0]        q, o;
        logic [3:0]        t;
        v = 10'(top_reg) - $signed({2'b00, grow_reg});
        a = v[9] ? (~v + 10'd1) : v;
        n = {a, 1'b0} + 11'(a) + 11'd5;
        q = div10(n);
        shift_next = v[9] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        o = div10(11'(fs_reg));
        off_next = (o == 8'd0) ? 5'd1 : o[4:0];
        t = div18(fs_reg);
        thick_next = (t == 4'd0) ? 4'd1 : t;
    end

    // Row and column bounds before clipping
    always_comb begin
        logic signed [CW-1:0] px_e, py_e, left_e, top_e, grow_e, gcol_e, shift_e;
        logic signed [CW-1:0] span_e, fs_e, fsh_e, off_e, t_e, ht_e, mid;
        px_e    = CW'(px_reg);
        py_e    = CW'(py_reg);
        left_e  = CW'(left_reg);
        top_e   = CW'(top_reg);
        shift_e = CW'(shift_reg);
        grow_e  = $signed(CW'(grow_reg));
        gcol_e  = $signed(CW'(gcol_reg));
        span_e  = $signed(CW'(span_reg));
        fs_e    = $signed(CW'(fs_reg));
        fsh_e   = $signed(CW'(fs_reg >> 1));
        off_e   = $signed(CW'(off_reg));
        t_e     = $signed(CW'(thick_reg));
        ht_e    = $signed(CW'(thick_reg >> 1));
        mid     = '0;
        col_lo_next = px_e;
        col_hi_next = px_e + span_e - CW'(1);
        row_lo_next = py_e;
        row_hi_next = py_e;
        unique case (kind_reg)
            REQ_GLYPH: begin
                col_lo_next = px_e + left_e + gcol_e + shift_e;
                col_hi_next = px_e + left_e + gcol_e + shift_e;
                row_lo_next = py_e - top_e + grow_e;
                row_hi_next = py_e - top_e + grow_e;
            end
            REQ_UNDERLINE: begin
                mid = py_e + off_e;
                row_lo_next = mid - ht_e;
                row_hi_next = mid + t_e - ht_e - CW'(1);
            end
            REQ_STRIKE: begin
                mid = py_e - fs_e + fsh_e + CW'(2);
                row_lo_next = mid - ht_e;
                row_hi_next = mid + ht_e;
            end
            REQ_READ: begin
                col_hi_next = px_e;
            end
        endcase
    end

    // Clip to the area in use
    logic signed [CW-1:0] c0, c1, r0, r1, clim, rlim;
    always_comb begin
        clim = $signed(CW'(area_cols)) - CW'(1);
        rlim = $signed(CW'(area_rows)) - CW'(1);
        c0 = (col_lo_reg < 0) ? '0 : col_lo_reg;
        c1 = (col_hi_reg > clim) ? clim : col_hi_reg;
        r0 = (row_lo_reg < 0) ? '0 : row_lo_reg;
        r1 = (row_hi_reg > rlim) ? rlim : row_hi_reg;
        ok_next = (c0 <= c1) && (r0 <= r1) && !(kind_reg == REQ_GLYPH && pv_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= req_type_t'(s_tuser);
            px_reg    <= s_tdata[POS_X_LSB +: POS_W];
            py_reg    <= s_tdata[POS_Y_LSB +: POS_W];
            left_reg  <= s_tdata[LEFT_LSB +: BEAR_W];
            top_reg   <= s_tdata[TOP_LSB +: BEAR_W];
            grow_reg  <= s_tdata[GROW_LSB +: GPOS_W];
            gcol_reg  <= s_tdata[GCOL_LSB +: GPOS_W];
            pv_reg    <= s_tdata[PIX_LSB +: PIX_W];
            span_reg  <= s_tdata[SPAN_LSB +: SPAN_W];
            fs_reg    <= s_tdata[FONT_LSB +: FONT_W];
            value_reg <= '0;
        end
        if (cmd.div) begin
            shift_reg <= shift_next;
            off_reg   <= off_next;
            thick_reg <= thick_next;
        end
        if (cmd.coord) begin
            row_lo_reg <= row_lo_next;
            row_hi_reg <= row_hi_next;
            col_lo_reg <= col_lo_next;
            col_hi_reg <= col_hi_next;
        end
        if (cmd.clip) begin
            col_first_reg <= c0[CFG_W-1:0];
            col_reg       <= c0[CFG_W-1:0];
            col_last_reg  <= c1[CFG_W-1:0];
            row_reg       <= r0[CFG_W-1:0];
            row_last_reg  <= r1[CFG_W-1:0];
            ok_reg        <= ok_next;
        end
        if (cmd.base) begin
            row_base_reg <= AW'(row_reg) * AW'(MASK_COLS);
        end
        if (cmd.fill_step) begin
            // advance along the span, wrap to the next row at its end
            if (col_reg == col_last_reg) begin
                col_reg      <= col_first_reg;
                row_reg      <= row_reg + CFG_W'(1);
                row_base_reg <= row_base_reg + AW'(MASK_COLS);
            end else begin
                col_reg <= col_reg + CFG_W'(1);
            end
        end
        if (cmd.merge && kind_reg == REQ_READ) begin
            value_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= value_reg;
            m_tuser_reg <= ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign pix_addr = row_base_reg + AW'(col_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = cmd.rd;
        ram_addr  = pix_addr;
        ram_wdata = ALPHA_FULL;
        priority if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.fill_step) begin
            ram_we = 1'b1;
        end else if (cmd.merge && kind_reg == REQ_GLYPH) begin
            ram_we    = 1'b1;
            ram_wdata = (pv_reg > ram_rdata) ? pv_reg : ram_rdata;
        end else begin
            ram_we = 1'b0;
        end
    end

    tamr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_alpha_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign sts.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.go       = ok_reg;
    assign sts.kind     = kind_reg;
    assign sts.col_end  = (col_reg == col_last_reg);
    assign sts.row_end  = (row_reg == row_last_reg);

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire

[src/tamr_ctrl.sv]
`default_nettype none

module tamr_ctrl import tamr_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire tamr_sts_t sts,
    output tamr_cmd_t      cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_DIV    = 10'b00_0000_0100,
        ST_COORD  = 10'b00_0000_1000,
        ST_CLIP   = 10'b00_0001_0000,
        ST_BASE   = 10'b00_0010_0000,
        ST_RD     = 10'b00_0100_0000,
        ST_MERGE  = 10'b00_1000_0000,
        ST_FILL   = 10'b01_0000_0000,
        ST_RESULT = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_COORD;
            end
            ST_COORD: begin
                cmd.coord  = 1'b1;
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                cmd.clip   = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.base = 1'b1;
                if (!sts.go) begin
                    state_next = ST_RESULT;
                end else if (sts.kind == REQ_GLYPH || sts.kind == REQ_READ) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.col_end && sts.row_end) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_tvalid_next = cmd.out_load | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

[verif/text_alpha_mask_raster_unit_tb.sv]
`timescale 1ns / 100ps

module text_alpha_mask_raster_unit_tb;
    import tamr_pkg::*;

    localparam int IMG_PIXELS     = MASK_ROWS_DEF * MASK_COLS_DEF;
    localparam int GAP_MAX        = 18;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RECENT_MAX     = 32;
    localparam int PRINT_MAX      = 100;

    typedef struct {
        req_type_t                kind;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [BEAR_W-1:0] left;
        logic signed [BEAR_W-1:0] top;
        logic [GPOS_W-1:0]        grow;
        logic [GPOS_W-1:0]        gcol;
        logic [PIX_W-1:0]         pix;
        logic [SPAN_W-1:0]        span;
        logic [FONT_W-1:0]        font;
        int                       gap;
    } raster_req_t;

    typedef struct {
        logic [PIX_W-1:0] read_value;
        logic             landed;
    } mask_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [REQ_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    text_alpha_mask_raster_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mask image and area registers as the block should hold them
    bit [PIX_W-1:0] alpha_img [IMG_PIXELS];
    int             cols_reg = 512;
    int             rows_reg = 512;

    raster_req_t  req_backlog[$];
    mask_result_t expected_results[$];
    int           recent_x[$];
    int           recent_y[$];
    int           pushed_total   = 0;
    int           accepted_total = 0;
    int           mismatch_count = 0;
    int           src_quiet_left = 0;

    function automatic int area_cols();
        return cols_reg < MASK_COLS_DEF ? cols_reg : MASK_COLS_DEF;
    endfunction

    function automatic int area_rows();
        return rows_reg < MASK_ROWS_DEF ? rows_reg : MASK_ROWS_DEF;
    endfunction

    function automatic bit point_in_area(int x, int y);
        return x >= 0 && y >= 0 && x < area_cols() && y < area_rows();
    endfunction

    // round(3*v/10), halves away from zero
    function automatic int shear_of(int v);
        int q;
        q = (3 * (v < 0 ? -v : v) + 5) / 10;
        return v < 0 ? -q : q;
    endfunction

    function automatic bit paint_band(int first, int last, int x, int w);
        bit any;
        int sx, ex, y, cx;
        any = 1'b0;
        sx = x > 0 ? x : 0;
        ex = x + w;
        if (ex > area_cols()) begin
            ex = area_cols();
        end
        for (y = first; y <= last; y++) begin
            if (y >= 0 && y < area_rows()) begin
                for (cx = sx; cx < ex; cx++) begin
                    alpha_img[y * MASK_COLS_DEF + cx] = ALPHA_FULL;
                    any = 1'b1;
                end
            end
        end
        return any;
    endfunction

    function automatic mask_result_t rasterize_request(raster_req_t r);
        mask_result_t res;
        int px, py, left, top, grow, gcol, w, fs, dx, dy, t, off, b, c, h, a;
        px   = r.pos_x;
        py   = r.pos_y;
        left = r.left;
        top  = r.top;
        grow = r.grow;
        gcol = r.gcol;
        w    = r.span;
        fs   = r.font;
        res.read_value = '0;
        res.landed     = 1'b0;
        t = fs / 18;
        if (t < 1) begin
            t = 1;
        end
        case (r.kind)
            REQ_GLYPH: begin
                if (r.pix != 0) begin
                    dx = px + left + gcol + shear_of(top - grow);
                    dy = py - top + grow;
                    if (point_in_area(dx, dy)) begin
                        a = dy * MASK_COLS_DEF + dx;
                        if (r.pix > alpha_img[a]) begin
                            alpha_img[a] = r.pix;
                        end
                        res.landed = 1'b1;
                    end
                end
            end
            REQ_UNDERLINE: begin
                off = fs / 10;
                if (off < 1) begin
                    off = 1;
                end
                b = py + off;
                res.landed = paint_band(b - t / 2, b + t - t / 2 - 1, px, w);
            end
            REQ_STRIKE: begin
                c = py - fs + fs / 2 + 2;
                h = t / 2;
                res.landed = paint_band(c - h, c + h, px, w);
            end
            default: begin
                if (point_in_area(px, py)) begin
                    res.read_value = alpha_img[py * MASK_COLS_DEF + px];
                    res.landed     = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    // Request driver
    raster_req_t cur_req;
    int          gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(rasterize_request(cur_req));
                accepted_total++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req  = req_backlog.pop_front();
                    gap_left = cur_req.gap;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.kind;
                    s_tdata  <= S_TDATA_W'({cur_req.font, cur_req.span, cur_req.pix,
                                            cur_req.gcol, cur_req.grow, cur_req.top,
                                            cur_req.left, cur_req.pos_y, cur_req.pos_x});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    mask_result_t want;
    int           stall_left   = 0;
    int           rx_quiet     = 0;
    int           hold_left    = 0;
    int           results_seen = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: read_value %0d landed %0b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.read_value) begin
                        report_mismatch($sformatf("result %0d read_value %0d, want %0d",
                                                  results_seen, m_tdata, want.read_value));
                    end
                    if (m_tuser !== want.landed) begin
                        report_mismatch($sformatf("result %0d landed %0b, want %0b",
                                                  results_seen, m_tuser, want.landed));
                    end
                end
                // hold off long enough to back the block up into its input
                if (results_seen == HOLD_AT_RESULT) begin
                    hold_left = HOLD_CYCLES;
                end
                if (rx_quiet > 0) begin
                    rx_quiet--;
                    stall_left = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        rx_quiet = $urandom_range(10, 40);
                    end
                    stall_left = $urandom_range(0, GAP_MAX);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic raster_req_t random_request();
        raster_req_t r;
        r.kind  = req_type_t'($urandom_range(0, 3));
        r.pos_x = POS_W'($urandom);
        r.pos_y = POS_W'($urandom);
        r.left  = BEAR_W'($urandom);
        r.top   = BEAR_W'($urandom);
        r.grow  = GPOS_W'($urandom);
        r.gcol  = GPOS_W'($urandom);
        r.pix   = PIX_W'($urandom);
        r.span  = SPAN_W'($urandom);
        r.font  = FONT_W'($urandom);
        if (src_quiet_left > 0) begin
            src_quiet_left--;
            r.gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                src_quiet_left = $urandom_range(10, 40);
            end
            r.gap = $urandom_range(0, GAP_MAX);
        end
        return r;
    endfunction

    function automatic void queue_request(raster_req_t r);
        req_backlog.push_back(r);
        pushed_total++;
    endfunction

    function automatic void push_glyph(int x, int y, int left, int top, int grow, int gcol,
                                       int pix);
        raster_req_t r;
        r       = random_request();
        r.kind  = REQ_GLYPH;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        r.left  = BEAR_W'(left);
        r.top   = BEAR_W'(top);
        r.grow  = GPOS_W'(grow);
        r.gcol  = GPOS_W'(gcol);
        r.pix   = PIX_W'(pix);
        queue_request(r);
    endfunction

    function automatic void push_fill(req_type_t kind, int x, int y, int span, int font);
        raster_req_t r;
        r       = random_request();
        r.kind  = kind;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        r.span  = SPAN_W'(span);
        r.font  = FONT_W'(font);
        queue_request(r);
    endfunction

    function automatic void push_read(int x, int y);
        raster_req_t r;
        r       = random_request();
        r.kind  = REQ_READ;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        queue_request(r);
    endfunction

    // Mostly requests that land inside the area; one in ten is pure noise
    function automatic raster_req_t aimed_request(int ac, int ar);
        raster_req_t r;
        int tx, ty, sel, left, top, grow, gcol, fs, k;
        r   = random_request();
        sel = $urandom_range(0, 99);
        if (sel < 10 || ac == 0 || ar == 0) begin
            return r;
        end
        tx = $urandom_range(0, ac - 1);
        ty = $urandom_range(0, ar - 1);
        if (sel < 52) begin
            left   = $urandom_range(0, 40);
            left   = left - 20;
            top    = $urandom_range(0, 60);
            top    = top - 10;
            grow   = $urandom_range(0, 40);
            gcol   = $urandom_range(0, 40);
            r.kind = REQ_GLYPH;
            r.left = BEAR_W'(left);
            r.top  = BEAR_W'(top);
            r.grow = GPOS_W'(grow);
            r.gcol = GPOS_W'(gcol);
            if ($urandom_range(0, 9) == 0) begin
                r.pix = '0;
            end
            r.pos_x = POS_W'(tx - left - gcol - shear_of(top - grow));
            r.pos_y = POS_W'(ty + top - grow);
            recent_x.push_back(tx);
            recent_y.push_back(ty);
            if (recent_x.size() > RECENT_MAX) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end else if (sel < 75) begin
            fs = r.font;
            k  = $urandom_range(0, 20);
            r.pos_x = POS_W'(tx - k);
            // place the band over the chosen row
            if ($urandom_range(0, 2) == 0) begin
                r.kind  = REQ_STRIKE;
                r.pos_y = POS_W'(ty + fs - fs / 2 - 2);
            end else begin
                r.kind  = REQ_UNDERLINE;
                r.pos_y = POS_W'(ty - (fs / 10 < 1 ? 1 : fs / 10));
            end
            if ($urandom_range(0, 29) != 0) begin
                r.span = SPAN_W'($urandom_range(0, 31));
            end
        end else begin
            r.kind = REQ_READ;
            if (recent_x.size() != 0 && $urandom_range(0, 2) != 0) begin
                k  = $urandom_range(0, recent_x.size() - 1);
                tx = recent_x[k];
                ty = recent_y[k];
            end
            r.pos_x = POS_W'(tx);
            r.pos_y = POS_W'(ty);
        end
        return r;
    endfunction

    task automatic wait_drained();
        @(posedge aclk);
        while (accepted_total != pushed_total || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_area(int cols, int rows);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLS_IN_USE;
        cfg_wdata <= CFG_W'(cols);
        @(posedge aclk);
        cols_reg = cols;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_wdata <= CFG_W'(rows);
        @(posedge aclk);
        rows_reg = rows;
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase_cols  [8] = '{1, 0, 1023, 300, 17, 512, 200, 512};
        int phase_rows  [8] = '{1, 0, 1023, 200, 509, 1, 512, 512};
        int phase_items [8] = '{30, 20, 150, 150, 120, 80, 150, 150};
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the full reset area
        push_glyph(0, 0, 0, 0, 0, 0, 255);
        push_glyph(0, 0, 0, 0, 0, 0, 0);
        push_glyph(0, 0, 0, 0, 0, 0, 1);
        push_read(0, 0);
        push_glyph(100, 100, 0, 5, 0, 0, 77);   // shear +1.5 rounds up
        push_glyph(100, 100, 0, 0, 5, 0, 99);   // shear -1.5 rounds down
        push_read(102, 95);
        push_read(98, 105);
        push_glyph(2047, -2048, 255, 255, 255, 255, 255);
        push_glyph(-2048, 2047, -256, -256, 0, 0, 128);
        push_glyph(511, 511, 0, 0, 0, 0, 200);
        push_read(511, 511);
        push_fill(REQ_UNDERLINE, 10, 20, 5, 0);
        push_read(12, 21);
        push_fill(REQ_UNDERLINE, -100, 300, 2047, 255);
        push_fill(REQ_UNDERLINE, 50, 50, 0, 40);
        push_fill(REQ_STRIKE, 5, 50, 3, 0);
        push_fill(REQ_STRIKE, 0, 400, 511, 255);
        push_fill(REQ_STRIKE, -2048, 100, 2047, 100);
        push_fill(REQ_UNDERLINE, 400, 490, 200, 255);
        push_read(-1, 0);
        push_read(512, 0);
        push_read(0, 512);
        push_read(2047, -2048);
        push_read(450, 510);

        // Random phases, each on its own area once the previous one has drained
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            set_area(phase_cols[p], phase_rows[p]);
            repeat (phase_items[p]) begin
                queue_request(aimed_request(area_cols(), area_rows()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("text_alpha_mask_raster_unit_tb passed");
        end else begin
            $display("text_alpha_mask_raster_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("text_alpha_mask_raster_unit_tb failed");
        $finish;
    end

endmodule
